[hdl/lkc_pkg.sv]
//------------------------------------------------------------------------------
// lkc_pkg
// shared types and constants for the lfu key cache
//------------------------------------------------------------------------------
package lkc_pkg;

	localparam int CAPACITY_DEF  = 16;
	localparam int KEY_BYTES_DEF = 5;
	localparam int QDEPTH        = 2;
	localparam logic [15:0] CNT_MAX = 16'hffff;

	typedef enum logic [1:0] {
		OP_PRELOAD = 2'd0,
		OP_ACCESS  = 2'd1,
		OP_READ    = 2'd2,
		OP_NOP     = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [39:0] key;
		logic [15:0] use_count;
		logic [3:0]  rank;
	} in_item_t;

	typedef struct packed {
		logic        hit;
		logic        evicted;
		logic [39:0] evicted_key;
		logic [39:0] result_key;
		logic [15:0] result_count;
		logic        found;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RANK,
		ST_APPLY,
		ST_OUT
	} bk_state_t;

endpackage

[hdl/lkc_front.sv]
//------------------------------------------------------------------------------
// lkc_front
// accepts items, masks the key and queues them for the back end
//------------------------------------------------------------------------------
module lkc_front
	import lkc_pkg::*;
#(
	parameter int KEY_BYTES = KEY_BYTES_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_data,
	output logic     q_valid,
	input  logic     q_ready,
	output in_item_t q_data
);

	localparam int KW = KEY_BYTES * 8;

	in_item_t        mem_q [QDEPTH];
	logic            wp_q, rp_q;
	logic [1:0]      cnt_q;
	in_item_t        masked;
	logic            push, pop;

	always_comb begin
		masked = in_data;
		masked.key = 40'(in_data.key[KW-1:0]);
	end

	assign in_ready = (cnt_q != 2'(QDEPTH));
	assign q_valid  = (cnt_q != 2'd0);
	assign q_data   = mem_q[rp_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= masked;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(QDEPTH)) else $error("queue count overflow");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'(QDEPTH) |-> !push) else $error("push into full queue");
	a_pop_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> cnt_q == $past(cnt_q) - 2'd1) else $error("pop count");

endmodule

[hdl/lkc_back.sv]
//------------------------------------------------------------------------------
// lkc_back
// scans entries one per cycle for lookup, victim, free slot and rank
//------------------------------------------------------------------------------
module lkc_back
	import lkc_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	output logic      q_ready,
	input  in_item_t  q_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	logic [39:0]   key_q   [CAPACITY];
	logic [15:0]   cnt_q   [CAPACITY];
	logic [CAPACITY-1:0] vld_q;
	logic [CW-1:0] occ_q;

	bk_state_t     st_q, st_d;
	in_item_t      it_q;
	logic [IW-1:0] i_q, j_q;
	logic          hitf_q, freef_q, vicf_q, foundf_q;
	logic [IW-1:0] hidx_q, fidx_q, vidx_q;
	logic [39:0]   vkey_q;
	logic [15:0]   vcnt_q;
	logic [CW-1:0] pos_q;
	out_item_t     res_q;
	out_item_t     out_q;
	logic          oval_q;

	logic [39:0]   rk_i, rk_j;
	logic [15:0]   rc_i, rc_j;
	logic          last_i, last_j;
	logic          j_before_i;

	assign rk_i = key_q[i_q];
	assign rc_i = cnt_q[i_q];
	assign rk_j = key_q[j_q];
	assign rc_j = cnt_q[j_q];
	assign last_i = (i_q == IW'(CAPACITY - 1));
	assign last_j = (j_q == IW'(CAPACITY - 1));
	assign j_before_i = (rc_j != rc_i) ? (rc_j < rc_i) : (rk_j < rk_i);

	assign q_ready   = (st_q == ST_IDLE);
	assign out_valid = oval_q;
	assign out_data  = out_q;

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (q_valid) begin
				st_d = (q_data.op == OP_READ) ? ST_RANK :
				       (q_data.op == OP_NOP) ? ST_OUT : ST_SCAN;
			end
			ST_SCAN: if (last_i) st_d = ST_APPLY;
			ST_RANK: if ((last_i && last_j) || foundf_q) st_d = ST_OUT;
			ST_APPLY: st_d = ST_OUT;
			ST_OUT: if (!oval_q || out_ready) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			vld_q  <= '0;
			occ_q  <= '0;
			oval_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_OUT && st_d == ST_IDLE) oval_q <= 1'b1;
			else if (out_ready) oval_q <= 1'b0;
			if (st_q == ST_APPLY && it_q.op != OP_READ) begin
				if (!hitf_q) begin
					if (freef_q) begin
						vld_q[fidx_q] <= 1'b1;
						occ_q <= occ_q + 1'b1;
					end else begin
						vld_q[vidx_q] <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_OUT && st_d == ST_IDLE) out_q <= res_q;
		case (st_q)
			ST_IDLE: begin
				it_q <= q_data;
				i_q <= '0;
				j_q <= '0;
				hitf_q <= 1'b0;
				freef_q <= 1'b0;
				vicf_q <= 1'b0;
				foundf_q <= 1'b0;
				pos_q <= '0;
				res_q <= '0;
			end
			ST_SCAN: begin
				if (vld_q[i_q] && rk_i == it_q.key && !hitf_q) begin
					hitf_q <= 1'b1;
					hidx_q <= i_q;
				end
				if (!vld_q[i_q] && !freef_q) begin
					freef_q <= 1'b1;
					fidx_q <= i_q;
				end
				if (vld_q[i_q] && (!vicf_q || rc_i < vcnt_q ||
				    (rc_i == vcnt_q && rk_i < vkey_q))) begin
					vicf_q <= 1'b1;
					vidx_q <= i_q;
					vkey_q <= rk_i;
					vcnt_q <= rc_i;
				end
				i_q <= i_q + 1'b1;
			end
			ST_APPLY: begin
				res_q.result_key <= it_q.key;
				if (hitf_q) begin
					res_q.hit <= 1'b1;
					if (it_q.op == OP_PRELOAD) begin
						cnt_q[hidx_q] <= it_q.use_count;
						res_q.result_count <= it_q.use_count;
					end else begin
						cnt_q[hidx_q] <= (cnt_q[hidx_q] == CNT_MAX) ? CNT_MAX :
							cnt_q[hidx_q] + 16'd1;
						res_q.result_count <= (cnt_q[hidx_q] == CNT_MAX) ? CNT_MAX :
							cnt_q[hidx_q] + 16'd1;
					end
				end else begin
					res_q.result_count <= (it_q.op == OP_PRELOAD) ? it_q.use_count : 16'd1;
					if (freef_q) begin
						key_q[fidx_q] <= it_q.key;
						cnt_q[fidx_q] <= (it_q.op == OP_PRELOAD) ? it_q.use_count : 16'd1;
					end else begin
						res_q.evicted <= 1'b1;
						res_q.evicted_key <= vkey_q;
						key_q[vidx_q] <= it_q.key;
						cnt_q[vidx_q] <= (it_q.op == OP_PRELOAD) ? it_q.use_count : 16'd1;
					end
				end
			end
			ST_RANK: begin
				if (!foundf_q) begin
					if (last_j) begin
						j_q <= '0;
						pos_q <= '0;
						i_q <= i_q + 1'b1;
						if (vld_q[i_q] && CW'(it_q.rank) ==
						    pos_q + CW'(vld_q[j_q] && j_q != i_q && j_before_i)) begin
							foundf_q <= 1'b1;
							res_q.found <= 1'b1;
							res_q.result_key <= rk_i;
							res_q.result_count <= rc_i;
						end
					end else begin
						if (vld_q[j_q] && j_q != i_q && j_before_i) pos_q <= pos_q + 1'b1;
						j_q <= j_q + 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	a_occ: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q == CW'($countones(vld_q))) else $error("occupancy mismatch");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		st_q != ST_IDLE |-> !q_ready) else $error("ready while busy");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		oval_q && !out_ready |=> oval_q && $stable(out_q)) else $error("result lost");

endmodule

[hdl/lfu_key_cache_unit.sv]
// the back end handles one item at a time and scans one entry per cycle
// a two-entry input queue lets new items be taken while the back end is busy
// reset clears all valid bits, occupancy and the queue at once
//------------------------------------------------------------------------------
// lfu_key_cache_unit
// least-frequently-used key cache with a decoupled front and back end
//------------------------------------------------------------------------------
module lfu_key_cache_unit
	import lkc_pkg::*;
#(
	parameter int CAPACITY  = CAPACITY_DEF,
	parameter int KEY_BYTES = KEY_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic     q_valid, q_ready;
	in_item_t q_data;

	lkc_front #(.KEY_BYTES(KEY_BYTES)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.q_valid, .q_ready, .q_data
	);

	lkc_back #(.CAPACITY(CAPACITY)) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_data,
		.out_valid, .out_ready, .out_data
	);

endmodule
